// ----- rtl/vtp_pkg.sv -----
package vtp_pkg;

  // Configuration register indexes, in the order of the register map.
  typedef enum logic [2:0] {
    REG_ROW0   = 3'd0,
    REG_ROW1   = 3'd1,
    REG_ROW2   = 3'd2,
    REG_ROW3   = 3'd3,
    REG_CENTER = 3'd4,
    REG_SCALE  = 3'd5,
    REG_HALF_W = 3'd6,
    REG_HALF_H = 3'd7
  } vtp_reg_t;

  localparam logic [63:0] ROW0_RST   = 64'd4096;
  localparam logic [63:0] ROW1_RST   = 64'd268435456;
  localparam logic [63:0] ROW2_RST   = 64'd17592186044416;
  localparam logic [63:0] ROW3_RST   = 64'd1152921504606846976;
  localparam logic [47:0] CENTER_RST = 48'd0;
  localparam logic [15:0] SCALE_RST  = 16'd4096;
  localparam logic [11:0] HALF_W_RST = 12'd400;
  localparam logic [11:0] HALF_H_RST = 12'd300;

  // Quotient magnitude bits produced by the divider; larger quotients saturate.
  localparam int QUOT_BITS = 21;

  localparam int SCR_MAX = 524287;
  localparam int SCR_MIN = -524288;
  localparam int DEP_MAX = 32767;
  localparam int DEP_MIN = -32768;

  // Per-vertex side information carried alongside the divider lanes.
  typedef struct packed {
    logic        wz;
    logic [2:0]  neg;
    logic [2:0]  ovf;
    logic [15:0] off_x;
    logic [15:0] off_y;
  } vtp_side_t;

endpackage

// ----- rtl/vtp_divider.sv -----
module vtp_divider #(
  parameter int LANES = 3,
  parameter int R_W   = 56,
  parameter int QB    = 21,
  parameter int SB_W  = 39
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [R_W-1:0]  in_num [LANES],
  input  logic [R_W-1:0]  in_den [LANES],
  input  logic [SB_W-1:0] in_side,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [QB-1:0]   out_quot [LANES],
  output logic [SB_W-1:0] out_side
);

  // Restoring division, one quotient bit per stage, most significant first.
  logic [QB-1:0]   v_r;
  logic [R_W-1:0]  r_r   [QB][LANES];
  logic [R_W-1:0]  d_r   [QB][LANES];
  logic [QB-1:0]   q_r   [QB][LANES];
  logic [SB_W-1:0] sb_r  [QB];
  logic [R_W-1:0]  r_nxt [QB][LANES];
  logic [QB-1:0]   q_nxt [QB][LANES];
  logic [QB-1:0]   pv;
  logic [QB:0]     en;

  assign pv = {v_r[QB-2:0], in_valid};

  always_comb begin
    en[QB] = out_ready;
    for (int s = QB - 1; s >= 0; s--) begin
      en[s] = !v_r[s] || en[s+1];
    end
  end

  always_comb begin
    logic [R_W-1:0] pr;
    logic [R_W-1:0] pd;
    logic [R_W-1:0] trial;
    logic [QB-1:0]  pq;
    for (int s = 0; s < QB; s++) begin
      for (int l = 0; l < LANES; l++) begin
        if (s == 0) begin
          pr = in_num[l];
          pd = in_den[l];
          pq = '0;
        end else begin
          pr = r_r[s-1][l];
          pd = d_r[s-1][l];
          pq = q_r[s-1][l];
        end
        trial = pd << (QB - 1 - s);
        if (pr >= trial) begin
          r_nxt[s][l] = pr - trial;
          q_nxt[s][l] = pq | (QB'(1) << (QB - 1 - s));
        end else begin
          r_nxt[s][l] = pr;
          q_nxt[s][l] = pq;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int s = 0; s < QB; s++) begin
        if (en[s]) v_r[s] <= pv[s];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int s = 0; s < QB; s++) begin
      if (en[s] && pv[s]) begin
        sb_r[s] <= (s == 0) ? in_side : sb_r[s-1];
        for (int l = 0; l < LANES; l++) begin
          r_r[s][l] <= r_nxt[s][l];
          q_r[s][l] <= q_nxt[s][l];
          d_r[s][l] <= (s == 0) ? in_den[l] : d_r[s-1][l];
        end
      end
    end
  end

  assign in_ready  = en[0];
  assign out_valid = v_r[QB-1];
  assign out_side  = sb_r[QB-1];
  always_comb begin
    for (int l = 0; l < LANES; l++) out_quot[l] = q_r[QB-1][l];
  end

  a_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> v_r[0])
    else $error("accepted divide did not enter the first stage");

  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !v_r[0] |-> in_ready)
    else $error("empty first stage refused a divide");

  for (genvar l = 0; l < LANES; l++) begin : g_chk
    a_rem: assert property (@(posedge clk) disable iff (!rst_n)
      out_valid |-> (r_r[QB-1][l] < d_r[QB-1][l]))
      else $error("final remainder not below divisor");
  end

endmodule

// ----- rtl/vertex_transform_project.sv -----
// Vertex transform: model-space vertex in, screen position and depth out.
//
// Input stream (in_*): one word per vertex carrying signed Q8.8 x, y and z.
// Output stream (out_*): one word per vertex with screen x and y in signed
// Q16.4 pixels and depth in signed Q4.12; tuser flags a zero clip w (no
// perspective divide) and any clamped output.
// Configuration (cfg_*): the matrix rows, model center, model scale and the
// half screen sizes are written one register per cycle and take effect for
// every vertex accepted afterwards. The user must write them only while no
// vertex is in flight; the block itself does not enforce this.
// Throughput is one vertex per clock while the receiver keeps out_tready high.
// The path has six stages for centering, scaling, the matrix products, the row
// sums with rounding, the numerator products and the divide setup, 21 stages of
// the restoring divider (one quotient bit each, three lanes side by side) and
// one stage for offset, clamping and the output register.
// Reset clears every stage valid bit and loads the identity matrix, zero
// center, unit scale and an 800 by 600 viewport. When the receiver holds off,
// the word waits in the output register and earlier stages keep filling any
// empty slot; in_tready falls only once every stage holds a vertex.
module vertex_transform_project #(
  parameter int COEF_FRAC_BITS = 12
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // vertex_x[15:0], vertex_y[31:16], vertex_z[47:32]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // screen_x[19:0], screen_y[39:20], depth_z[55:40]
  output logic [1:0]  out_tuser,  // w_was_zero[0], saturated[1]
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_wdata
);

  localparam int F      = COEF_FRAC_BITS;
  localparam int C_W    = 34;                // centered and scaled coordinate
  localparam int P_W    = 50;                // one matrix product
  localparam int ACC_W  = 52;                // row sum
  localparam int CLIP_W = ACC_W - 8 - F;     // clip coordinate, F fraction bits
  localparam int NUM_W  = CLIP_W + 16;       // numerator magnitude
  localparam int R_W    = CLIP_W + 24;       // divider remainder
  localparam int QB     = vtp_pkg::QUOT_BITS;
  localparam int G_W    = QB + 3;
  localparam int SB_W   = $bits(vtp_pkg::vtp_side_t);

  localparam logic signed [G_W-1:0] SX_HI = G_W'(vtp_pkg::SCR_MAX);
  localparam logic signed [G_W-1:0] SX_LO = G_W'(vtp_pkg::SCR_MIN);
  localparam logic signed [G_W-1:0] DZ_HI = G_W'(vtp_pkg::DEP_MAX);
  localparam logic signed [G_W-1:0] DZ_LO = G_W'(vtp_pkg::DEP_MIN);

  // Configuration registers.
  logic [63:0] row_r [4];
  logic [47:0] center_r;
  logic [15:0] scale_r;
  logic [11:0] hw_r;
  logic [11:0] hh_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r[0] <= vtp_pkg::ROW0_RST;
      row_r[1] <= vtp_pkg::ROW1_RST;
      row_r[2] <= vtp_pkg::ROW2_RST;
      row_r[3] <= vtp_pkg::ROW3_RST;
      center_r <= vtp_pkg::CENTER_RST;
      scale_r  <= vtp_pkg::SCALE_RST;
      hw_r     <= vtp_pkg::HALF_W_RST;
      hh_r     <= vtp_pkg::HALF_H_RST;
    end else if (cfg_we) begin
      case (vtp_pkg::vtp_reg_t'(cfg_index))
        vtp_pkg::REG_ROW0:   row_r[0] <= cfg_wdata;
        vtp_pkg::REG_ROW1:   row_r[1] <= cfg_wdata;
        vtp_pkg::REG_ROW2:   row_r[2] <= cfg_wdata;
        vtp_pkg::REG_ROW3:   row_r[3] <= cfg_wdata;
        vtp_pkg::REG_CENTER: center_r <= cfg_wdata[47:0];
        vtp_pkg::REG_SCALE:  scale_r  <= cfg_wdata[15:0];
        vtp_pkg::REG_HALF_W: hw_r     <= cfg_wdata[11:0];
        vtp_pkg::REG_HALF_H: hh_r     <= cfg_wdata[11:0];
        default: ;
      endcase
    end
  end

  // Stage valid bits and the enable chain. A stage loads whenever it is
  // empty or the stage after it loads, so bubbles close up under a stall.
  logic a_v_r, b_v_r, c_v_r, d_v_r, e_v_r, f_v_r, g_v_r;
  logic en_a, en_b, en_c, en_d, en_e, en_f, en_g;
  logic div_in_ready, div_out_valid;

  assign en_g = !g_v_r || out_tready;
  assign en_f = !f_v_r || div_in_ready;
  assign en_e = !e_v_r || en_f;
  assign en_d = !d_v_r || en_e;
  assign en_c = !c_v_r || en_d;
  assign en_b = !b_v_r || en_c;
  assign en_a = !a_v_r || en_b;
  assign in_tready = en_a;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
      c_v_r <= 1'b0;
      d_v_r <= 1'b0;
      e_v_r <= 1'b0;
      f_v_r <= 1'b0;
      g_v_r <= 1'b0;
    end else begin
      if (en_a) a_v_r <= in_tvalid;
      if (en_b) b_v_r <= a_v_r;
      if (en_c) c_v_r <= b_v_r;
      if (en_d) d_v_r <= c_v_r;
      if (en_e) e_v_r <= d_v_r;
      if (en_f) f_v_r <= e_v_r;
      if (en_g) g_v_r <= div_out_valid;
    end
  end

  // Stage A: subtract the model center.
  logic signed [16:0] a_d_r   [3];
  logic signed [16:0] a_d_nxt [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      a_d_nxt[i] = {in_tdata[16*i+15], in_tdata[16*i +: 16]}
                 - {center_r[16*i+15], center_r[16*i +: 16]};
    end
  end

  always_ff @(posedge clk) begin
    if (en_a && in_tvalid) a_d_r <= a_d_nxt;
  end

  // Stage B: apply the model scale; 8+F fraction bits, exact.
  logic signed [C_W-1:0] b_c_r   [3];
  logic signed [C_W-1:0] b_c_nxt [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      b_c_nxt[i] = a_d_r[i] * $signed({1'b0, scale_r});
    end
  end

  always_ff @(posedge clk) begin
    if (en_b && a_v_r) b_c_r <= b_c_nxt;
  end

  // Stage C: the twelve matrix products.
  logic signed [P_W-1:0] c_p_r   [4][3];
  logic signed [P_W-1:0] c_p_nxt [4][3];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 3; j++) begin
        c_p_nxt[i][j] = $signed(row_r[i][16*j +: 16]) * b_c_r[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en_c && b_v_r) c_p_r <= c_p_nxt;
  end

  // Stage D: row sums with the translation column, rounded to F fraction
  // bits, nearest with ties away from zero.
  logic signed [CLIP_W-1:0] d_clip_r   [4];
  logic signed [CLIP_W-1:0] d_clip_nxt [4];

  always_comb begin
    logic signed [ACC_W-1:0] acc;
    logic [ACC_W-1:0]        am;
    logic [ACC_W-1:0]        rm;
    for (int i = 0; i < 4; i++) begin
      acc = ACC_W'(c_p_r[i][0]) + ACC_W'(c_p_r[i][1]) + ACC_W'(c_p_r[i][2])
          + (ACC_W'($signed(row_r[i][63:48])) <<< (8 + F));
      am  = acc[ACC_W-1] ? ACC_W'(-acc) : ACC_W'(acc);
      rm  = (am + (ACC_W'(1) << (7 + F))) >> (8 + F);
      d_clip_nxt[i] = acc[ACC_W-1] ? -$signed(rm[CLIP_W-1:0]) : $signed(rm[CLIP_W-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (en_d && c_v_r) d_clip_r <= d_clip_nxt;
  end

  // Stage E: numerator and divisor magnitudes. A zero w is handled as a
  // divide by 2^F, which gives the same rounding as the plain shift.
  logic [NUM_W-1:0]    e_an_r   [3];
  logic [NUM_W-1:0]    e_an_nxt [3];
  logic [CLIP_W-1:0]   e_ad_r;
  logic [CLIP_W-1:0]   e_ad_nxt;
  vtp_pkg::vtp_side_t  e_side_r;
  vtp_pkg::vtp_side_t  e_side_nxt;

  always_comb begin
    logic [15:0]            hw16;
    logic [15:0]            hh16;
    logic signed [CLIP_W+16:0] px;
    logic signed [CLIP_W+16:0] py;
    logic [CLIP_W+16:0]     mx;
    logic [CLIP_W+16:0]     my;
    logic [CLIP_W-1:0]      mz;
    logic [CLIP_W-1:0]      mw;
    logic                   wz;
    hw16 = {hw_r, 4'b0000};
    hh16 = {hh_r, 4'b0000};
    px   = $signed({1'b0, hw16}) * d_clip_r[0];
    py   = $signed({1'b0, hh16}) * d_clip_r[1];
    mx   = px[CLIP_W+16] ? (CLIP_W+17)'(-px) : (CLIP_W+17)'(px);
    my   = py[CLIP_W+16] ? (CLIP_W+17)'(-py) : (CLIP_W+17)'(py);
    mz   = d_clip_r[2][CLIP_W-1] ? CLIP_W'(-d_clip_r[2]) : CLIP_W'(d_clip_r[2]);
    mw   = d_clip_r[3][CLIP_W-1] ? CLIP_W'(-d_clip_r[3]) : CLIP_W'(d_clip_r[3]);
    wz   = (d_clip_r[3] == '0);

    e_an_nxt[0] = mx[NUM_W-1:0];
    e_an_nxt[1] = my[NUM_W-1:0];
    e_an_nxt[2] = NUM_W'(mz) << F;
    e_ad_nxt    = wz ? (CLIP_W'(1) << F) : mw;

    e_side_nxt.wz    = wz;
    e_side_nxt.neg   = {d_clip_r[2][CLIP_W-1] ^ d_clip_r[3][CLIP_W-1],
                        d_clip_r[1][CLIP_W-1] ^ d_clip_r[3][CLIP_W-1],
                        d_clip_r[0][CLIP_W-1] ^ d_clip_r[3][CLIP_W-1]};
    e_side_nxt.ovf   = 3'b000;
    e_side_nxt.off_x = wz ? 16'd0 : hw16;
    e_side_nxt.off_y = wz ? 16'd0 : hh16;
  end

  always_ff @(posedge clk) begin
    if (en_e && d_v_r) begin
      e_an_r   <= e_an_nxt;
      e_ad_r   <= e_ad_nxt;
      e_side_r <= e_side_nxt;
    end
  end

  // Stage F: rounded division as floor((2n + d) / 2d). Quotients that need
  // more than QB bits are flagged here and clamp at the end.
  logic [R_W-1:0]     f_num_r   [3];
  logic [R_W-1:0]     f_den_r   [3];
  logic [R_W-1:0]     f_num_nxt [3];
  logic [R_W-1:0]     f_den_nxt [3];
  vtp_pkg::vtp_side_t f_side_r;
  vtp_pkg::vtp_side_t f_side_nxt;

  always_comb begin
    logic [R_W-1:0] n;
    logic [R_W-1:0] dd;
    f_side_nxt = e_side_r;
    for (int i = 0; i < 3; i++) begin
      n  = (R_W'(e_an_r[i]) << 1) + R_W'(e_ad_r);
      dd = R_W'(e_ad_r) << 1;
      f_side_nxt.ovf[i] = (n >= (dd << QB));
      f_num_nxt[i] = f_side_nxt.ovf[i] ? '0 : n;
      f_den_nxt[i] = dd;
    end
  end

  always_ff @(posedge clk) begin
    if (en_f && e_v_r) begin
      f_num_r  <= f_num_nxt;
      f_den_r  <= f_den_nxt;
      f_side_r <= f_side_nxt;
    end
  end

  logic [QB-1:0]      div_quot [3];
  logic [SB_W-1:0]    div_side_raw;
  vtp_pkg::vtp_side_t div_side;

  vtp_divider #(
    .LANES (3),
    .R_W   (R_W),
    .QB    (QB),
    .SB_W  (SB_W)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (f_v_r),
    .in_ready  (div_in_ready),
    .in_num    (f_num_r),
    .in_den    (f_den_r),
    .in_side   (f_side_r),
    .out_valid (div_out_valid),
    .out_ready (en_g),
    .out_quot  (div_quot),
    .out_side  (div_side_raw)
  );

  assign div_side = vtp_pkg::vtp_side_t'(div_side_raw);

  // Stage G: sign, viewport offset, clamping and the output register.
  logic [55:0] out_tdata_r;
  logic [1:0]  out_tuser_r;
  logic [55:0] g_data_nxt;
  logic [1:0]  g_user_nxt;

  always_comb begin
    logic [QB:0]            qm;
    logic signed [G_W-1:0]  sv [3];
    logic signed [G_W-1:0]  cl [3];
    logic                   sat;
    sat = 1'b0;
    for (int i = 0; i < 3; i++) begin
      qm    = div_side.ovf[i] ? ((QB+1)'(1) << QB) : {1'b0, div_quot[i]};
      sv[i] = $signed({2'b00, qm});
      if (div_side.neg[i]) sv[i] = -sv[i];
    end
    sv[0] = sv[0] + $signed({{(G_W-16){1'b0}}, div_side.off_x});
    sv[1] = sv[1] + $signed({{(G_W-16){1'b0}}, div_side.off_y});
    for (int i = 0; i < 2; i++) begin
      if (sv[i] > SX_HI) begin
        cl[i] = SX_HI;
        sat   = 1'b1;
      end else if (sv[i] < SX_LO) begin
        cl[i] = SX_LO;
        sat   = 1'b1;
      end else begin
        cl[i] = sv[i];
      end
    end
    if (sv[2] > DZ_HI) begin
      cl[2] = DZ_HI;
      sat   = 1'b1;
    end else if (sv[2] < DZ_LO) begin
      cl[2] = DZ_LO;
      sat   = 1'b1;
    end else begin
      cl[2] = sv[2];
    end
    g_data_nxt = {cl[2][15:0], cl[1][19:0], cl[0][19:0]};
    g_user_nxt = {sat, div_side.wz};
  end

  always_ff @(posedge clk) begin
    if (en_g && div_out_valid) begin
      out_tdata_r <= g_data_nxt;
      out_tuser_r <= g_user_nxt;
    end
  end

  assign out_tvalid = g_v_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  a_in_open: assert property (@(posedge clk) disable iff (!rst_n)
    !a_v_r |-> in_tready)
    else $error("input refused while the first stage is empty");

  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    div_out_valid && en_g |=> out_tvalid)
    else $error("divider result lost before the output register");

  a_ovf_sat: assert property (@(posedge clk) disable iff (!rst_n)
    div_out_valid && en_g && (div_side.ovf != 3'b000) |=> out_tuser[1])
    else $error("quotient overflow did not flag saturation");

endmodule

// ----- tb/sv/vertex_transform_checker.sv -----
module vertex_transform_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [47:0] in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [55:0] out_tdata,
  input  logic [1:0]  out_tuser,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_wdata,
  output int          fail_count,
  output int          pending_count
);

  localparam int FRAC = 12;

  typedef struct packed {
    logic [19:0] scr_x;
    logic [19:0] scr_y;
    logic [15:0] depth;
    logic        wz;
    logic        sat;
  } screen_word_t;

  logic [63:0] row_q [4];
  logic [47:0] center_q;
  logic [15:0] scale_q;
  logic [11:0] half_w_q;
  logic [11:0] half_h_q;

  screen_word_t screen_q [$];

  function automatic longint round_shift(longint v, int s);
    longint a;
    a = ((v < 0 ? -v : v) + (64'sd1 <<< (s - 1))) >>> s;
    return v < 0 ? -a : a;
  endfunction

  function automatic longint round_div(longint n, longint d);
    longint an, ad, q;
    an = n < 0 ? -n : n;
    ad = d < 0 ? -d : d;
    q = (2 * an + ad) / (2 * ad);
    return ((n < 0) != (d < 0)) ? -q : q;
  endfunction

  function automatic longint clamp(longint v, longint lo, longint hi, inout logic sat);
    if (v > hi) begin
      sat = 1'b1;
      return hi;
    end
    if (v < lo) begin
      sat = 1'b1;
      return lo;
    end
    return v;
  endfunction

  function automatic screen_word_t project_vertex(logic [47:0] vtx);
    longint c [3];
    longint clip [4];
    longint acc, hw, hh, sx, sy, dz;
    logic sat;
    screen_word_t r;
    sat = 1'b0;
    hw = longint'(half_w_q);
    hh = longint'(half_h_q);
    for (int i = 0; i < 3; i++)
      c[i] = (longint'($signed(vtx[16*i +: 16])) - longint'($signed(center_q[16*i +: 16])))
             * longint'(scale_q);
    for (int i = 0; i < 4; i++) begin
      acc = longint'($signed(row_q[i][63:48])) <<< (8 + FRAC);
      for (int j = 0; j < 3; j++)
        acc += longint'($signed(row_q[i][16*j +: 16])) * c[j];
      clip[i] = round_shift(acc, 8 + FRAC);
    end
    r.wz = (clip[3] == 0);
    if (!r.wz) begin
      sx = round_div(hw * 16 * clip[0], clip[3]) + hw * 16;
      sy = round_div(hh * 16 * clip[1], clip[3]) + hh * 16;
      dz = round_div(clip[2] <<< FRAC, clip[3]);
    end else begin
      sx = round_shift(hw * 16 * clip[0], FRAC);
      sy = round_shift(hh * 16 * clip[1], FRAC);
      dz = clip[2];
    end
    sx = clamp(sx, vtp_pkg::SCR_MIN, vtp_pkg::SCR_MAX, sat);
    sy = clamp(sy, vtp_pkg::SCR_MIN, vtp_pkg::SCR_MAX, sat);
    dz = clamp(dz, vtp_pkg::DEP_MIN, vtp_pkg::DEP_MAX, sat);
    r.scr_x = sx[19:0];
    r.scr_y = sy[19:0];
    r.depth = dz[15:0];
    r.sat = sat;
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  assign pending_count = screen_q.size();

  always @(posedge clk) begin
    screen_word_t want;
    if (!rst_n) begin
      row_q[0] <= vtp_pkg::ROW0_RST;
      row_q[1] <= vtp_pkg::ROW1_RST;
      row_q[2] <= vtp_pkg::ROW2_RST;
      row_q[3] <= vtp_pkg::ROW3_RST;
      center_q <= vtp_pkg::CENTER_RST;
      scale_q <= vtp_pkg::SCALE_RST;
      half_w_q <= vtp_pkg::HALF_W_RST;
      half_h_q <= vtp_pkg::HALF_H_RST;
    end else begin
      if (in_tvalid && in_tready) screen_q = {screen_q, project_vertex(in_tdata)};
      if (out_tvalid && out_tready) begin
        if (screen_q.size() == 0) begin
          report_mismatch("unexpected word", 1, 0);
        end else begin
          want = screen_q.pop_front();
          if (out_tdata[19:0] !== want.scr_x)
            report_mismatch("screen_x", $signed(out_tdata[19:0]), $signed(want.scr_x));
          if (out_tdata[39:20] !== want.scr_y)
            report_mismatch("screen_y", $signed(out_tdata[39:20]), $signed(want.scr_y));
          if (out_tdata[55:40] !== want.depth)
            report_mismatch("depth_z", $signed(out_tdata[55:40]), $signed(want.depth));
          if (out_tuser[0] !== want.wz) report_mismatch("w_was_zero", out_tuser[0], want.wz);
          if (out_tuser[1] !== want.sat) report_mismatch("saturated", out_tuser[1], want.sat);
        end
      end
      if (cfg_we) begin
        case (vtp_pkg::vtp_reg_t'(cfg_index))
          vtp_pkg::REG_ROW0, vtp_pkg::REG_ROW1, vtp_pkg::REG_ROW2, vtp_pkg::REG_ROW3:
            row_q[cfg_index[1:0]] <= cfg_wdata;
          vtp_pkg::REG_CENTER: center_q <= cfg_wdata[47:0];
          vtp_pkg::REG_SCALE:  scale_q <= cfg_wdata[15:0];
          vtp_pkg::REG_HALF_W: half_w_q <= cfg_wdata[11:0];
          vtp_pkg::REG_HALF_H: half_h_q <= cfg_wdata[11:0];
          default: ;
        endcase
      end
    end
  end

endmodule

// ----- tb/sv/vertex_transform_project_test.sv -----
module vertex_transform_project_test;

  localparam int LATENCY = 28;
  localparam int CYCLE_LIMIT = 400000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [55:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [63:0] cfg_wdata = '0;
  int          fail_count;
  int          pending_count;
  int          cycle_count = 0;
  // When set, the receiver runs a long hold-off so the pipeline fills.
  logic        hold_request = 1'b0;

  always #5 clk = ~clk;

  vertex_transform_project dut (.*);

  vertex_transform_checker checker_i (.*);

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Receiver: random stalls between words, plus one long hold-off
  // when asked for. Changes are made on the falling edge only.
  initial begin
    int gap;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        out_tready <= 1'b0;
        repeat (200) @(negedge clk);
        hold_request = 1'b0;
      end
      gap = $urandom_range(0, 5);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap != 0) begin
        out_tready <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end else begin
        out_tready <= 1'b1;
        do @(posedge clk); while (!(out_tvalid && out_tready));
      end
    end
  end

  // One word offered after a random gap, held until the block takes it.
  // The valid stays up on return; the next word or a drain takes it down.
  task automatic send_vertex(logic [15:0] vx, logic [15:0] vy, logic [15:0] vz,
                             bit no_gap = 0);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 5);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {vz, vy, vx};
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  // Waits for every expected word, then lets the pipeline drain fully.
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
  endtask

  task automatic write_reg(vtp_pkg::vtp_reg_t idx, logic [63:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // A random Q4.12 coefficient, mostly moderate so results stay in range.
  function automatic logic [15:0] rand_coef();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      default: return 16'($signed($urandom_range(0, 8192)) - 4096);
    endcase
  endfunction

  // Loads a random setting: a mix of extreme and moderate values.
  task automatic load_setting(bit extremes);
    for (int r = 0; r < 4; r++)
      write_reg(vtp_pkg::vtp_reg_t'(r), extremes ? {$urandom, $urandom}
                : {rand_coef(), rand_coef(), rand_coef(), rand_coef()});
    write_reg(vtp_pkg::REG_CENTER, extremes ? {$urandom, $urandom}
              : {16'($urandom_range(0, 511) - 256), 16'($urandom_range(0, 511) - 256),
                 16'($urandom_range(0, 511) - 256)});
    write_reg(vtp_pkg::REG_SCALE, extremes ? 64'($urandom_range(0, 16'hffff))
              : 64'($urandom_range(1024, 8192)));
    write_reg(vtp_pkg::REG_HALF_W, extremes ? 64'($urandom_range(0, 1) ? 12'hfff : 12'd1)
              : 64'($urandom_range(1, 4095)));
    write_reg(vtp_pkg::REG_HALF_H, extremes ? 64'($urandom_range(0, 1) ? 12'hfff : 12'd0)
              : 64'($urandom_range(1, 4095)));
  endtask

  task automatic random_vertices(int count, bit small_range);
    logic [15:0] v [3];
    for (int n = 0; n < count; n++) begin
      for (int a = 0; a < 3; a++)
        v[a] = small_range ? 16'($urandom_range(0, 4095) - 2048) : 16'($urandom);
      send_vertex(v[0], v[1], v[2], $urandom_range(0, 4) == 0);
    end
  endtask

  initial begin
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: identity matrix with field extremes, so clip w is one.
    send_vertex(16'h0000, 16'h0000, 16'h0000);
    send_vertex(16'h7fff, 16'h7fff, 16'h7fff);
    send_vertex(16'h8000, 16'h8000, 16'h8000);
    send_vertex(16'h0100, 16'hff00, 16'h0080);
    send_vertex(16'h0001, 16'hffff, 16'h5555);
    send_vertex(16'haaaa, 16'h5555, 16'haaaa);
    wait_drained();

    // Zero w: the bottom row is cleared, so clip w is zero and w_was_zero is set.
    write_reg(vtp_pkg::REG_ROW3, 64'd0);
    send_vertex(16'h0100, 16'h0200, 16'h0300);
    send_vertex(16'h7fff, 16'h8000, 16'h7fff);
    send_vertex(16'hff00, 16'h0080, 16'h8000);
    wait_drained();

    // Negative w and a small w near zero; zero half height; odd center.
    write_reg(vtp_pkg::REG_ROW3, {16'hf000, 16'h0000, 16'h0000, 16'h0000});
    write_reg(vtp_pkg::REG_HALF_H, 64'd0);
    write_reg(vtp_pkg::REG_HALF_W, 64'd4095);
    write_reg(vtp_pkg::REG_CENTER, {16'h8000, 16'h7fff, 16'h0001});
    send_vertex(16'h0100, 16'h0100, 16'h0100);
    send_vertex(16'h8000, 16'h7fff, 16'h0000);
    wait_drained();
    write_reg(vtp_pkg::REG_ROW3, {16'h0000, 16'h0000, 16'h0000, 16'h0001});
    write_reg(vtp_pkg::REG_SCALE, 64'hffff);
    send_vertex(16'h0000, 16'h0000, 16'h1000);
    send_vertex(16'h0000, 16'h0000, 16'hf000);
    // The register index bits are all covered by the writes above.
    wait_drained();

    // Long receiver hold-off while the sender keeps offering vertices.
    load_setting(0);
    hold_request = 1'b1;
    random_vertices(80, 1);
    wait_drained();

    // Random phases over several settings, the extremes among them.
    for (int phase = 0; phase < 10; phase++) begin
      load_setting(phase % 3 == 2);
      random_vertices(95, phase % 2 == 0);
      wait_drained();
    end

    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ----- vertex_transform_project.f -----
rtl/vtp_pkg.sv
rtl/vtp_divider.sv
rtl/vertex_transform_project.sv
tb/sv/vertex_transform_checker.sv
tb/sv/vertex_transform_project_test.sv
